FILE: hdl/ptd_pkg.sv
// shared constants and types for the point to triangle distance pipeline
`timescale 1ns / 1ps

package ptd_pkg;

  // weight format: Q0.16 with one extra bit so that one itself fits
  localparam int WEIGHT_BITS  = 16;
  localparam int WEIGHT_WIDTH = WEIGHT_BITS + 1;

  // multiplier: limb products, row sums, final sum
  localparam int MUL_LAT    = 3;
  localparam int LIMB_WIDTH = 32;

  // divider: one check stage, then one quotient bit per stage
  localparam int RATIO_LAT = WEIGHT_BITS + 1;

  typedef logic [WEIGHT_WIDTH-1:0] weight_t;

  localparam weight_t WEIGHT_ONE = weight_t'(1) << WEIGHT_BITS;

endpackage

FILE: hdl/ptd_if.sv
// valid/ready channel interfaces for query words and result words
`timescale 1ns / 1ps

interface ptd_query_if #(parameter int COORD_WIDTH = 32);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] query_x;
  logic signed [COORD_WIDTH-1:0] query_y;
  logic signed [COORD_WIDTH-1:0] query_z;
  logic signed [COORD_WIDTH-1:0] corner0_x;
  logic signed [COORD_WIDTH-1:0] corner0_y;
  logic signed [COORD_WIDTH-1:0] corner0_z;
  logic signed [COORD_WIDTH-1:0] corner1_x;
  logic signed [COORD_WIDTH-1:0] corner1_y;
  logic signed [COORD_WIDTH-1:0] corner1_z;
  logic signed [COORD_WIDTH-1:0] corner2_x;
  logic signed [COORD_WIDTH-1:0] corner2_y;
  logic signed [COORD_WIDTH-1:0] corner2_z;

  modport source (
    output valid, query_x, query_y, query_z, corner0_x, corner0_y, corner0_z,
           corner1_x, corner1_y, corner1_z, corner2_x, corner2_y, corner2_z,
    input  ready
  );
  modport sink (
    input  valid, query_x, query_y, query_z, corner0_x, corner0_y, corner0_z,
           corner1_x, corner1_y, corner1_z, corner2_x, corner2_y, corner2_z,
    output ready
  );
endinterface

interface ptd_result_if #(parameter int COORD_WIDTH = 32);
  logic                   valid;
  logic                   ready;
  logic [COORD_WIDTH-1:0] distance;
  ptd_pkg::weight_t       weight_s;
  ptd_pkg::weight_t       weight_t;

  modport source (output valid, distance, weight_s, weight_t, input ready);
  modport sink (input valid, distance, weight_s, weight_t, output ready);
endinterface

FILE: hdl/ptd_mul.sv
// pipelined signed multiplier built from 32x32 limb products
`timescale 1ns / 1ps

module ptd_mul #(
  parameter int A_WIDTH = 33,
  parameter int B_WIDTH = 33
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [A_WIDTH-1:0]         a,
  input  logic signed [B_WIDTH-1:0]         b,
  output logic signed [A_WIDTH+B_WIDTH-1:0] p
);
  import ptd_pkg::*;

  localparam int P_WIDTH = A_WIDTH + B_WIDTH;
  localparam int NL      = (P_WIDTH + LIMB_WIDTH - 1) / LIMB_WIDTH;
  localparam int XW      = NL * LIMB_WIDTH;

  logic [XW-1:0]           ax;
  logic [XW-1:0]           bx;
  logic [2*LIMB_WIDTH-1:0] pp [NL][NL];
  logic [XW-1:0]           row_next [NL];
  logic [XW-1:0]           row [NL];
  logic [XW-1:0]           total_next;

  // sign extend so that the product modulo 2^XW is the signed product
  assign ax = {{(XW-A_WIDTH){a[A_WIDTH-1]}}, a};
  assign bx = {{(XW-B_WIDTH){b[B_WIDTH-1]}}, b};

  // stage 1: limb products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NL; i++) begin
        for (int j = 0; j < NL; j++) begin
          pp[i][j] <= (2*LIMB_WIDTH)'(ax[i*LIMB_WIDTH +: LIMB_WIDTH])
                    * (2*LIMB_WIDTH)'(bx[j*LIMB_WIDTH +: LIMB_WIDTH]);
        end
      end
    end
  end

  // stage 2: one row sum per limb of a
  always_comb begin
    for (int i = 0; i < NL; i++) begin
      row_next[i] = '0;
      for (int j = 0; j < NL; j++) begin
        row_next[i] = row_next[i] + (XW'(pp[i][j]) << ((i + j) * LIMB_WIDTH));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      row <= row_next;
    end
  end

  // stage 3: sum of rows
  always_comb begin
    total_next = '0;
    for (int i = 0; i < NL; i++) begin
      total_next = total_next + row[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p <= $signed(total_next[P_WIDTH-1:0]);
    end
  end

endmodule

FILE: hdl/ptd_delay.sv
// stallable delay line that keeps side data aligned with the pipeline
`timescale 1ns / 1ps

module ptd_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);
  logic [WIDTH-1:0] line [DEPTH];

  // shift on every advance
  always_ff @(posedge clk) begin
    if (en) begin
      line[0] <= d;
      for (int k = 1; k < DEPTH; k++) begin
        line[k] <= line[k-1];
      end
    end
  end

  assign q = line[DEPTH-1];

endmodule

FILE: hdl/ptd_ratio.sv
// pipelined clamped ratio num/den in Q0.16, one quotient bit per stage
`timescale 1ns / 1ps

module ptd_ratio #(
  parameter int N_WIDTH = 137
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [N_WIDTH-1:0] num,
  input  logic signed [N_WIDTH-1:0] den,
  output ptd_pkg::weight_t          q
);
  import ptd_pkg::*;

  localparam int UW = N_WIDTH - 1;

  logic [UW-1:0]          rem_r  [WEIGHT_BITS];
  logic [UW-1:0]          den_r  [WEIGHT_BITS];
  logic [WEIGHT_BITS-1:0] q_r    [WEIGHT_BITS+1];
  logic                   zero_r [WEIGHT_BITS+1];
  logic                   full_r [WEIGHT_BITS+1];
  logic [UW:0]            two    [1:WEIGHT_BITS];
  logic [UW:0]            sub    [1:WEIGHT_BITS];
  logic                   ge     [1:WEIGHT_BITS];

  // restoring step: remainder stays below the denominator
  always_comb begin
    for (int k = 1; k <= WEIGHT_BITS; k++) begin
      two[k] = {rem_r[k-1], 1'b0};
      ge[k]  = two[k] >= {1'b0, den_r[k-1]};
      sub[k] = two[k] - {1'b0, den_r[k-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // check stage: non-positive operands give zero, num >= den gives one
      zero_r[0] <= den[N_WIDTH-1] || (den == '0) || num[N_WIDTH-1] || (num == '0);
      full_r[0] <= num >= den;
      rem_r[0]  <= num[UW-1:0];
      den_r[0]  <= den[UW-1:0];
      q_r[0]    <= '0;
      for (int k = 1; k <= WEIGHT_BITS; k++) begin
        q_r[k]    <= {q_r[k-1][WEIGHT_BITS-2:0], ge[k]};
        zero_r[k] <= zero_r[k-1];
        full_r[k] <= full_r[k-1];
      end
      for (int k = 1; k < WEIGHT_BITS; k++) begin
        rem_r[k] <= ge[k] ? sub[k][UW-1:0] : two[k][UW-1:0];
        den_r[k] <= den_r[k-1];
      end
    end
  end

  assign q = zero_r[WEIGHT_BITS] ? '0 :
             full_r[WEIGHT_BITS] ? WEIGHT_ONE : {1'b0, q_r[WEIGHT_BITS]};

endmodule

FILE: hdl/ptd_sqrt.sv
// pipelined integer square root, one root bit per stage, with saturation
`timescale 1ns / 1ps

module ptd_sqrt #(
  parameter int ROOT_WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [2*ROOT_WIDTH-1:0]   x,
  input  logic                      sat,
  output logic [ROOT_WIDTH-1:0]     root
);
  localparam int R   = ROOT_WIDTH;
  localparam int XW  = 2 * R;
  localparam int CXW = XW + 1;

  logic [XW-1:0]  x_r    [R];
  logic [XW-1:0]  sq_r   [R];
  logic [R-1:0]   root_r [R+1];
  logic           sat_r  [R+1];
  logic [CXW-1:0] cand   [1:R];
  logic           le     [1:R];

  // candidate square (root | bit)^2 from the running square
  always_comb begin
    int b;
    for (int k = 1; k <= R; k++) begin
      b       = R - k;
      cand[k] = CXW'(sq_r[k-1]) + (CXW'(root_r[k-1]) << (b + 1)) + (CXW'(1) << (2 * b));
      le[k]   = cand[k] <= CXW'(x_r[k-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= x;
      sq_r[0]   <= '0;
      root_r[0] <= '0;
      sat_r[0]  <= sat;
      for (int k = 1; k <= R; k++) begin
        root_r[k] <= le[k] ? (root_r[k-1] | (R'(1) << (R - k))) : root_r[k-1];
        sat_r[k]  <= sat_r[k-1];
      end
      for (int k = 1; k < R; k++) begin
        x_r[k]  <= x_r[k-1];
        sq_r[k] <= le[k] ? cand[k][XW-1:0] : sq_r[k-1];
      end
    end
  end

  assign root = sat_r[R] ? '1 : root_r[R];

endmodule

FILE: hdl/point_triangle_distance.sv
// top level: closest point on a triangle, distance and clamped weights
//
//   channel  dir  handshake      word
//   query    in   valid / ready  query point and three corners, signed
//   result   out  valid / ready  distance, weight_s, weight_t
//
// One word per cycle while the result word is taken; each word passes
// through four multiplier pipelines, the 17-stage divider and the
// one-bit-per-stage square root.
// The whole pipeline advances together; when the result word is not taken
// every stage holds and query.ready drops in the same cycle.
// rst clears the valid bits only; no state outlives a word.
`timescale 1ns / 1ps

module point_triangle_distance #(
  parameter int COORD_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst,
  ptd_query_if.sink     query,
  ptd_result_if.source  result
);
  import ptd_pkg::*;

  localparam int CW     = COORD_WIDTH;
  localparam int EW     = CW + 1;
  localparam int DW     = 2 * EW + 2;
  localparam int QW     = 2 * DW + 1;
  localparam int MW     = WEIGHT_WIDTH + 1;
  localparam int FW     = EW + WEIGHT_BITS + 3;
  localparam int D2W    = 2 * FW + 2;
  localparam int L_SIDE = 4 + 2 * MUL_LAT + RATIO_LAT;
  localparam int L_WVEC = 4 + 3 * MUL_LAT + RATIO_LAT;
  localparam int L_WT   = 2 + 2 * MUL_LAT + CW;
  localparam int LAT    = 8 + 4 * MUL_LAT + RATIO_LAT + CW;

  typedef struct packed {
    logic signed [DW:0]   neg_d;
    logic signed [DW:0]   neg_e;
    logic signed [DW+1:0] denom;
    logic signed [DW+1:0] numer;
    logic signed [DW-1:0] a;
    logic signed [DW-1:0] c;
    logic                 d_neg;
    logic                 ce_gt;
    logic                 ad_gt;
  } deriv_t;

  typedef enum logic [1:0] {REG_S_EDGE, REG_T_EDGE, REG_INSIDE, REG_HYP} region_t;

  logic                    adv;
  logic [LAT-1:0]          vld;
  logic signed [CW-1:0]    qp [3];
  logic signed [CW-1:0]    v0 [3];
  logic signed [CW-1:0]    v1 [3];
  logic signed [CW-1:0]    v2 [3];
  logic signed [EW-1:0]    side0 [3];
  logic signed [EW-1:0]    side1 [3];
  logic signed [EW-1:0]    wvec [3];
  logic signed [2*EW-1:0]  pa [3];
  logic signed [2*EW-1:0]  pb [3];
  logic signed [2*EW-1:0]  pc [3];
  logic signed [2*EW-1:0]  pd [3];
  logic signed [2*EW-1:0]  pe [3];
  logic signed [DW-1:0]    dot_a, dot_b, dot_c, dot_d, dot_e;
  logic signed [2*DW-1:0]  prod_ac, prod_bb, prod_be, prod_cd, prod_bd, prod_ae;
  deriv_t                  drv;
  deriv_t                  drv_q;
  logic signed [QW-1:0]    det, sdet, tdet;
  logic signed [QW:0]      sum_st;
  region_t                 region;
  logic signed [QW-1:0]    ns, ds, nt, dt;
  logic signed [QW-1:0]    num_s, den_s, num_t, den_t;
  logic                    tmode;
  logic                    tmode_q;
  weight_t                 qs, qt;
  weight_t                 ws, wt;
  logic [6*EW-1:0]         side_pack, side_dly;
  logic [3*EW-1:0]         wvec_pack, wvec_dly;
  logic signed [EW-1:0]    sd0 [3];
  logic signed [EW-1:0]    sd1 [3];
  logic signed [EW-1:0]    wvq [3];
  logic signed [MW+EW-1:0] ps [3];
  logic signed [MW+EW-1:0] pt [3];
  logic signed [FW-1:0]    diff [3];
  logic signed [2*FW-1:0]  dsq [3];
  logic signed [D2W-1:0]   dsum;
  logic [2*CW-1:0]         sq_in;
  logic                    sq_sat;
  logic [CW-1:0]           root;
  logic [2*WEIGHT_WIDTH-1:0] wts_dly;
  logic [CW-1:0]           dist_r;
  weight_t                 ws_r, wt_r;

  // global advance: every stage moves unless the result word is held
  assign adv         = !vld[LAT-1] || result.ready;
  assign query.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], query.valid};
    end
  end

  assign qp[0] = query.query_x;
  assign qp[1] = query.query_y;
  assign qp[2] = query.query_z;
  assign v0[0] = query.corner0_x;
  assign v0[1] = query.corner0_y;
  assign v0[2] = query.corner0_z;
  assign v1[0] = query.corner1_x;
  assign v1[1] = query.corner1_y;
  assign v1[2] = query.corner1_z;
  assign v2[0] = query.corner2_x;
  assign v2[1] = query.corner2_y;
  assign v2[2] = query.corner2_z;

  // edge vectors and corner-to-query offset
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        side0[k] <= EW'(v1[k]) - EW'(v0[k]);
        side1[k] <= EW'(v2[k]) - EW'(v0[k]);
        wvec[k]  <= EW'(v0[k]) - EW'(qp[k]);
      end
    end
  end

  // dot product terms
  for (genvar k = 0; k < 3; k++) begin : g_dot
    ptd_mul #(.A_WIDTH(EW), .B_WIDTH(EW)) u_mul_a (
      .clk(clk), .en(adv), .a(side0[k]), .b(side0[k]), .p(pa[k]));
    ptd_mul #(.A_WIDTH(EW), .B_WIDTH(EW)) u_mul_b (
      .clk(clk), .en(adv), .a(side0[k]), .b(side1[k]), .p(pb[k]));
    ptd_mul #(.A_WIDTH(EW), .B_WIDTH(EW)) u_mul_c (
      .clk(clk), .en(adv), .a(side1[k]), .b(side1[k]), .p(pc[k]));
    ptd_mul #(.A_WIDTH(EW), .B_WIDTH(EW)) u_mul_d (
      .clk(clk), .en(adv), .a(side0[k]), .b(wvec[k]), .p(pd[k]));
    ptd_mul #(.A_WIDTH(EW), .B_WIDTH(EW)) u_mul_e (
      .clk(clk), .en(adv), .a(side1[k]), .b(wvec[k]), .p(pe[k]));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dot_a <= DW'(pa[0]) + DW'(pa[1]) + DW'(pa[2]);
      dot_b <= DW'(pb[0]) + DW'(pb[1]) + DW'(pb[2]);
      dot_c <= DW'(pc[0]) + DW'(pc[1]) + DW'(pc[2]);
      dot_d <= DW'(pd[0]) + DW'(pd[1]) + DW'(pd[2]);
      dot_e <= DW'(pe[0]) + DW'(pe[1]) + DW'(pe[2]);
    end
  end

  // cross products for det, s and t
  ptd_mul #(.A_WIDTH(DW), .B_WIDTH(DW)) u_mul_ac (
    .clk(clk), .en(adv), .a(dot_a), .b(dot_c), .p(prod_ac));
  ptd_mul #(.A_WIDTH(DW), .B_WIDTH(DW)) u_mul_bb (
    .clk(clk), .en(adv), .a(dot_b), .b(dot_b), .p(prod_bb));
  ptd_mul #(.A_WIDTH(DW), .B_WIDTH(DW)) u_mul_be (
    .clk(clk), .en(adv), .a(dot_b), .b(dot_e), .p(prod_be));
  ptd_mul #(.A_WIDTH(DW), .B_WIDTH(DW)) u_mul_cd (
    .clk(clk), .en(adv), .a(dot_c), .b(dot_d), .p(prod_cd));
  ptd_mul #(.A_WIDTH(DW), .B_WIDTH(DW)) u_mul_bd (
    .clk(clk), .en(adv), .a(dot_b), .b(dot_d), .p(prod_bd));
  ptd_mul #(.A_WIDTH(DW), .B_WIDTH(DW)) u_mul_ae (
    .clk(clk), .en(adv), .a(dot_a), .b(dot_e), .p(prod_ae));

  // edge numerators and the region tests, in parallel with the products
  always_ff @(posedge clk) begin
    if (adv) begin
      drv.neg_d <= -(DW+1)'(dot_d);
      drv.neg_e <= -(DW+1)'(dot_e);
      drv.denom <= (DW+2)'(dot_a) + (DW+2)'(dot_c) - ((DW+2)'(dot_b) <<< 1);
      drv.numer <= (DW+2)'(dot_c) + (DW+2)'(dot_e) - (DW+2)'(dot_b) - (DW+2)'(dot_d);
      drv.a     <= dot_a;
      drv.c     <= dot_c;
      drv.d_neg <= dot_d[DW-1];
      drv.ce_gt <= ((DW+2)'(dot_c) + (DW+2)'(dot_e)) > ((DW+2)'(dot_b) + (DW+2)'(dot_d));
      drv.ad_gt <= ((DW+2)'(dot_a) + (DW+2)'(dot_d)) > ((DW+2)'(dot_b) + (DW+2)'(dot_e));
    end
  end

  ptd_delay #(.WIDTH($bits(deriv_t)), .DEPTH(MUL_LAT)) u_dly_drv (
    .clk(clk), .en(adv), .d(drv), .q(drv_q));

  always_ff @(posedge clk) begin
    if (adv) begin
      det  <= QW'(prod_ac) - QW'(prod_bb);
      sdet <= QW'(prod_be) - QW'(prod_cd);
      tdet <= QW'(prod_bd) - QW'(prod_ae);
    end
  end

  // seven-region classification
  always_comb begin
    sum_st = (QW+1)'(sdet) + (QW+1)'(tdet);
    if (sum_st < (QW+1)'(det)) begin
      if (sdet[QW-1]) begin
        region = (tdet[QW-1] && drv_q.d_neg) ? REG_S_EDGE : REG_T_EDGE;
      end else if (tdet[QW-1]) begin
        region = REG_S_EDGE;
      end else begin
        region = REG_INSIDE;
      end
    end else begin
      if (sdet[QW-1]) begin
        region = drv_q.ce_gt ? REG_HYP : REG_T_EDGE;
      end else if (tdet[QW-1]) begin
        region = drv_q.ad_gt ? REG_HYP : REG_S_EDGE;
      end else begin
        region = REG_HYP;
      end
    end
  end

  // pick ratio operands; a zero numerator forces a zero weight
  always_comb begin
    ns = '0;
    ds = '0;
    nt = '0;
    dt = '0;
    unique case (region)
      REG_S_EDGE: begin
        ns = QW'(drv_q.neg_d);
        ds = QW'(drv_q.a);
      end
      REG_T_EDGE: begin
        nt = QW'(drv_q.neg_e);
        dt = QW'(drv_q.c);
      end
      REG_INSIDE: begin
        ns = sdet;
        ds = det;
        nt = tdet;
        dt = det;
      end
      REG_HYP: begin
        ns = QW'(drv_q.numer);
        ds = QW'(drv_q.denom);
      end
      default: begin
        ns = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num_s <= ns;
      den_s <= ds;
      num_t <= nt;
      den_t <= dt;
      tmode <= region == REG_HYP;
    end
  end

  ptd_ratio #(.N_WIDTH(QW)) u_ratio_s (
    .clk(clk), .en(adv), .num(num_s), .den(den_s), .q(qs));
  ptd_ratio #(.N_WIDTH(QW)) u_ratio_t (
    .clk(clk), .en(adv), .num(num_t), .den(den_t), .q(qt));

  ptd_delay #(.WIDTH(1), .DEPTH(RATIO_LAT)) u_dly_tmode (
    .clk(clk), .en(adv), .d(tmode), .q(tmode_q));

  // on the far edge t is one minus s
  always_ff @(posedge clk) begin
    if (adv) begin
      ws <= qs;
      wt <= tmode_q ? WEIGHT_ONE - qs : qt;
    end
  end

  // edge vectors and offset carried alongside the division
  assign side_pack = {side1[2], side1[1], side1[0], side0[2], side0[1], side0[0]};
  assign wvec_pack = {wvec[2], wvec[1], wvec[0]};

  ptd_delay #(.WIDTH(6*EW), .DEPTH(L_SIDE)) u_dly_side (
    .clk(clk), .en(adv), .d(side_pack), .q(side_dly));
  ptd_delay #(.WIDTH(3*EW), .DEPTH(L_WVEC)) u_dly_wvec (
    .clk(clk), .en(adv), .d(wvec_pack), .q(wvec_dly));

  for (genvar k = 0; k < 3; k++) begin : g_diff
    assign sd0[k] = $signed(side_dly[k*EW +: EW]);
    assign sd1[k] = $signed(side_dly[(k+3)*EW +: EW]);
    assign wvq[k] = $signed(wvec_dly[k*EW +: EW]);

    ptd_mul #(.A_WIDTH(MW), .B_WIDTH(EW)) u_mul_s (
      .clk(clk), .en(adv), .a($signed({1'b0, ws})), .b(sd0[k]), .p(ps[k]));
    ptd_mul #(.A_WIDTH(MW), .B_WIDTH(EW)) u_mul_t (
      .clk(clk), .en(adv), .a($signed({1'b0, wt})), .b(sd1[k]), .p(pt[k]));

    // query minus closest point, scaled by one in Q0.16
    always_ff @(posedge clk) begin
      if (adv) begin
        diff[k] <= -(FW'(wvq[k]) <<< WEIGHT_BITS) - FW'(ps[k]) - FW'(pt[k]);
      end
    end

    ptd_mul #(.A_WIDTH(FW), .B_WIDTH(FW)) u_mul_sq (
      .clk(clk), .en(adv), .a(diff[k]), .b(diff[k]), .p(dsq[k]));
  end

  // squared distance back to coordinate units, saturation flag
  assign dsum   = D2W'(dsq[0]) + D2W'(dsq[1]) + D2W'(dsq[2]);
  assign sq_in  = dsum[2*WEIGHT_BITS +: 2*CW];
  assign sq_sat = |dsum[D2W-1:2*WEIGHT_BITS+2*CW];

  ptd_sqrt #(.ROOT_WIDTH(CW)) u_sqrt (
    .clk(clk), .en(adv), .x(sq_in), .sat(sq_sat), .root(root));

  ptd_delay #(.WIDTH(2*WEIGHT_WIDTH), .DEPTH(L_WT)) u_dly_wts (
    .clk(clk), .en(adv), .d({wt, ws}), .q(wts_dly));

  // output register
  always_ff @(posedge clk) begin
    if (adv) begin
      dist_r <= root;
      ws_r   <= wts_dly[WEIGHT_WIDTH-1:0];
      wt_r   <= wts_dly[2*WEIGHT_WIDTH-1:WEIGHT_WIDTH];
    end
  end

  assign result.valid    = vld[LAT-1];
  assign result.distance = dist_r;
  assign result.weight_s = ws_r;
  assign result.weight_t = wt_r;

`ifndef ASSERT_OFF
  // weights never add up to more than one
  assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (({1'b0, result.weight_s} + {1'b0, result.weight_t})
                      <= {1'b0, WEIGHT_ONE}))
    else $error("weight sum above one");

  // a held result word blocks new query words
  assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.ready) |-> !query.ready)
    else $error("query taken while result stalled");

  // reset empties the pipeline
  assert property (@(posedge clk) rst |=> !result.valid)
    else $error("result valid right after reset");
`endif

endmodule

FILE: test/testbench.sv
// testbench for point_triangle_distance: exact closest point predictor and result scoreboard
`timescale 1ns / 1ps

typedef logic signed [255:0] wide_t;

typedef struct {
  logic signed [31:0] c[12];  // P, V0, V1, V2, each x y z
} tri_query_t;

typedef struct {
  logic [31:0]      distance;
  ptd_pkg::weight_t weight_s;
  ptd_pkg::weight_t weight_t;
} tri_result_t;

// scoreboard: predicts each accepted query and checks results in order
class distance_scoreboard;
  tri_result_t pending[$];
  int          errors;

  function new();
    errors = 0;
  endfunction

  // clamp(num/den, 0, 1) in Q0.16, truncated, zero denominator gives 0
  static function ptd_pkg::weight_t clamp_ratio(wide_t num, wide_t den);
    wide_t q;
    if (den <= 0 || num <= 0) return '0;
    if (num >= den) return ptd_pkg::WEIGHT_ONE;
    q = (num * 65536) / den;
    return q[16:0];
  endfunction

  static function tri_result_t closest_point(tri_query_t w);
    wide_t p[3], v0[3], e0[3], e1[3], wv[3];
    wide_t a, b, c, d, e, det, sd, td, denom, numer, sw, tw, diff, dist2, root, cw;
    ptd_pkg::weight_t s, t;
    tri_result_t r;
    for (int k = 0; k < 3; k++) begin
      p[k]  = w.c[k];
      v0[k] = w.c[3+k];
      e0[k] = wide_t'(w.c[6+k]) - v0[k];
      e1[k] = wide_t'(w.c[9+k]) - v0[k];
      wv[k] = v0[k] - p[k];
    end
    a = e0[0]*e0[0] + e0[1]*e0[1] + e0[2]*e0[2];
    b = e0[0]*e1[0] + e0[1]*e1[1] + e0[2]*e1[2];
    c = e1[0]*e1[0] + e1[1]*e1[1] + e1[2]*e1[2];
    d = e0[0]*wv[0] + e0[1]*wv[1] + e0[2]*wv[2];
    e = e1[0]*wv[0] + e1[1]*wv[1] + e1[2]*wv[2];
    det = a*c - b*b;
    sd = b*e - c*d;
    td = b*d - a*e;
    denom = (a + c) - (b + b);
    numer = (c + e) - (b + d);
    // seven-region classification
    if (sd + td < det) begin
      if (sd < 0) begin
        if (td < 0 && d < 0) begin
          s = clamp_ratio(-d, a); t = '0;
        end else begin
          s = '0; t = clamp_ratio(-e, c);
        end
      end else if (td < 0) begin
        s = clamp_ratio(-d, a); t = '0;
      end else begin
        s = clamp_ratio(sd, det); t = clamp_ratio(td, det);
      end
    end else begin
      if (sd < 0) begin
        if (c + e > b + d) begin
          s = clamp_ratio(numer, denom); t = ptd_pkg::WEIGHT_ONE - s;
        end else begin
          s = '0; t = clamp_ratio(-e, c);
        end
      end else if (td < 0) begin
        if (a + d > b + e) begin
          s = clamp_ratio(numer, denom); t = ptd_pkg::WEIGHT_ONE - s;
        end else begin
          s = clamp_ratio(-d, a); t = '0;
        end
      end else begin
        s = clamp_ratio(numer, denom); t = ptd_pkg::WEIGHT_ONE - s;
      end
    end
    // squared distance at full product precision
    sw = s;
    tw = t;
    dist2 = 0;
    for (int k = 0; k < 3; k++) begin
      diff = -wv[k]*65536 - sw*e0[k] - tw*e1[k];
      dist2 = dist2 + diff*diff;
    end
    dist2 = dist2 >>> 32;
    // floor square root, saturated
    root = 0;
    if (dist2 >= (wide_t'(1) << 64)) begin
      root = 32'hFFFF_FFFF;
    end else begin
      for (int i = 31; i >= 0; i--) begin
        cw = root | (wide_t'(1) << i);
        if (cw*cw <= dist2) root = cw;
      end
    end
    r.distance = root[31:0];
    r.weight_s = s;
    r.weight_t = t;
    return r;
  endfunction

  function void note_query(tri_query_t w);
    pending.push_back(closest_point(w));
  endfunction

  function void check_result(tri_result_t got);
    tri_result_t want;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result distance %h s %h t %h", $time,
               got.distance, got.weight_s, got.weight_t);
      errors++;
      return;
    end
    want = pending.pop_front();
    if (got.distance !== want.distance) begin
      $display("%0t: distance expected %h actual %h", $time, want.distance, got.distance);
      errors++;
    end
    if (got.weight_s !== want.weight_s) begin
      $display("%0t: weight_s expected %h actual %h", $time, want.weight_s, got.weight_s);
      errors++;
    end
    if (got.weight_t !== want.weight_t) begin
      $display("%0t: weight_t expected %h actual %h", $time, want.weight_t, got.weight_t);
      errors++;
    end
  endfunction
endclass

module testbench;
  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   calm = 1'b0;      // no idling on either side
  bit   hold_req = 1'b0;  // receiver holds off for a long stretch

  ptd_query_if  #(.COORD_WIDTH(32)) q ();
  ptd_result_if #(.COORD_WIDTH(32)) r ();

  point_triangle_distance #(.COORD_WIDTH(32)) dut (
    .clk   (clk),
    .rst   (rst),
    .query (q),
    .result(r)
  );

  distance_scoreboard sb = new();

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // watch both channels
  always @(posedge clk) begin
    tri_query_t  w;
    tri_result_t got;
    if (!rst && q.valid && q.ready) begin
      w.c = '{q.query_x, q.query_y, q.query_z, q.corner0_x, q.corner0_y, q.corner0_z,
              q.corner1_x, q.corner1_y, q.corner1_z, q.corner2_x, q.corner2_y, q.corner2_z};
      sb.note_query(w);
    end
    if (!rst && r.valid && r.ready) begin
      got.distance = r.distance;
      got.weight_s = r.weight_s;
      got.weight_t = r.weight_t;
      sb.check_result(got);
    end
  end

  // result side: random stall bursts, one long hold-off on request
  initial begin
    r.ready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        r.ready <= 1'b0;
        for (int n = 0; n < 400; n++) @(posedge clk);
        hold_req = 1'b0;
        r.ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        r.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        r.ready <= 1'b1;
      end else begin
        r.ready <= 1'b1;
      end
    end
  end

  task automatic send_query(tri_query_t w);
    q.query_x   <= w.c[0];  q.query_y   <= w.c[1];  q.query_z   <= w.c[2];
    q.corner0_x <= w.c[3];  q.corner0_y <= w.c[4];  q.corner0_z <= w.c[5];
    q.corner1_x <= w.c[6];  q.corner1_y <= w.c[7];  q.corner1_z <= w.c[8];
    q.corner2_x <= w.c[9];  q.corner2_y <= w.c[10]; q.corner2_z <= w.c[11];
    q.valid <= 1'b1;
    @(posedge clk);
    while (!q.ready) @(posedge clk);
    // random gap after the word
    if (!calm && $urandom_range(0, 4) == 0) begin
      q.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  function automatic tri_query_t make_tri(int p[3], int a[3], int b[3], int c[3]);
    tri_query_t w;
    for (int k = 0; k < 3; k++) begin
      w.c[k] = p[k]; w.c[3+k] = a[k]; w.c[6+k] = b[k]; w.c[9+k] = c[k];
    end
    return w;
  endfunction

  // random word: full range, small coordinates, or a triangle near the point
  function automatic tri_query_t random_query();
    tri_query_t w;
    int unsigned mode, span;
    int base;
    mode = $urandom_range(0, 9);
    span = 1 << $urandom_range(4, 22);
    base = $urandom;
    for (int i = 0; i < 12; i++) begin
      if (mode < 2) w.c[i] = $urandom;
      else if (mode < 6) w.c[i] = int'($urandom_range(0, 2*span)) - int'(span);
      else w.c[i] = (base >>> 2) + int'($urandom_range(0, 2*span)) - int'(span);
    end
    // occasional degenerate shapes
    if ($urandom_range(0, 15) == 0)
      for (int k = 0; k < 3; k++) w.c[9+k] = w.c[6+k];
    else if ($urandom_range(0, 15) == 0)
      for (int k = 0; k < 3; k++) w.c[6+k] = w.c[3+k];
    return w;
  endfunction

  localparam int ONE = 65536;
  localparam int MX  = 32'h7FFF_FFFF;
  localparam int MN  = 32'h8000_0000;

  initial begin
    tri_query_t dir[$];
    q.valid = 1'b0;
    q.query_x = '0;   q.query_y = '0;   q.query_z = '0;
    q.corner0_x = '0; q.corner0_y = '0; q.corner0_z = '0;
    q.corner1_x = '0; q.corner1_y = '0; q.corner1_z = '0;
    q.corner2_x = '0; q.corner2_y = '0; q.corner2_z = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: each region, degenerate triangles, extremes, far point
    dir.push_back(make_tri('{0,0,0}, '{0,0,0}, '{0,0,0}, '{0,0,0}));
    dir.push_back(make_tri('{ONE/4,ONE/4,ONE}, '{0,0,0}, '{ONE,0,0}, '{0,ONE,0}));
    dir.push_back(make_tri('{ONE/3,ONE/3,0}, '{0,0,0}, '{ONE,0,0}, '{0,ONE,0}));
    dir.push_back(make_tri('{-ONE,-ONE,ONE}, '{0,0,0}, '{ONE,0,0}, '{0,ONE,0}));
    dir.push_back(make_tri('{ONE/2,-ONE,0}, '{0,0,0}, '{ONE,0,0}, '{0,ONE,0}));
    dir.push_back(make_tri('{-ONE,ONE/2,0}, '{0,0,0}, '{ONE,0,0}, '{0,ONE,0}));
    dir.push_back(make_tri('{ONE,ONE,0}, '{0,0,0}, '{ONE,0,0}, '{0,ONE,0}));
    dir.push_back(make_tri('{3*ONE,-ONE,0}, '{0,0,0}, '{ONE,0,0}, '{0,ONE,0}));
    dir.push_back(make_tri('{-ONE,3*ONE,0}, '{0,0,0}, '{ONE,0,0}, '{0,ONE,0}));
    dir.push_back(make_tri('{2*ONE,-5,7}, '{0,0,0}, '{ONE,0,0}, '{0,ONE,0}));
    dir.push_back(make_tri('{5,6,7}, '{ONE,ONE,ONE}, '{ONE,ONE,ONE}, '{ONE,ONE,ONE}));
    dir.push_back(make_tri('{ONE,0,0}, '{0,0,0}, '{2*ONE,0,0}, '{4*ONE,0,0}));
    dir.push_back(make_tri('{ONE,ONE,0}, '{0,0,0}, '{0,0,0}, '{0,2*ONE,0}));
    dir.push_back(make_tri('{ONE,ONE,0}, '{0,0,0}, '{2*ONE,0,0}, '{0,0,0}));
    dir.push_back(make_tri('{MX,MX,MX}, '{MN,MN,MN}, '{MN,MN,MN}, '{MN,MN,MN}));
    dir.push_back(make_tri('{MN,MN,MN}, '{MX,MX,MX}, '{MX,MN,MX}, '{MN,MX,MX}));
    dir.push_back(make_tri('{MX,MN,MX}, '{MN,MX,MN}, '{MX,MX,MN}, '{MN,MN,MX}));
    dir.push_back(make_tri('{-1,-1,-1}, '{MX,MX,MX}, '{MX,MX,MX}, '{MX,MX,MX}));
    dir.push_back(make_tri('{0,0,0}, '{MN,0,0}, '{MX,0,0}, '{0,MX,MN}));
    dir.push_back(make_tri('{1,2,3}, '{-1,-1,-1}, '{-1,-1,0}, '{-1,0,-1}));
    foreach (dir[i]) send_query(dir[i]);

    // random traffic with one long result hold-off and one drain pause
    for (int i = 0; i < 900; i++) begin
      if (i == 200) hold_req = 1'b1;
      if (i == 450) begin
        q.valid <= 1'b0;
        wait_drained();
        @(posedge clk);
      end
      if (i == 750) calm = 1'b1;
      send_query(random_query());
    end
    q.valid <= 1'b0;

    for (int n = 0; n < 100000 && sb.pending.size() != 0; n++) @(posedge clk);
    repeat (150) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("point_triangle_distance verification clean");
    else
      $display("point_triangle_distance verification failed");
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("point_triangle_distance verification failed");
    $finish;
  end
endmodule

FILE: point_triangle_distance.f
hdl/ptd_pkg.sv
hdl/ptd_if.sv
hdl/ptd_mul.sv
hdl/ptd_delay.sv
hdl/ptd_ratio.sv
hdl/ptd_sqrt.sv
hdl/point_triangle_distance.sv
test/testbench.sv
